// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DPT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Digraph pair table package
// Types, codes and defaults shared by the pair table modules.
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int unsigned TableSizeDefault = 64;
  localparam int unsigned EntryW           = 24;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_FULL     = 3'd2,
    ST_DEFINED  = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_MISSING  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    RD_ZERO  = 2'd0,
    RD_NEXT  = 2'd1,
    RD_NEXT2 = 2'd2
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    ptr_inc;
    logic    set_res;
    status_e st_code;
    logic    res_from_ram;
    logic    add_write;
    logic    shift_write;
    logic    dec_count;
    logic    clear_tab;
    logic    load_out;
    rd_sel_e rd_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_e mode;
    logic  count_zero;
    logic  full;
    logic  missing_add;
    logic  missing_rm;
    logic  hit;
    logic  last;
    logic  out_free;
  } stat_t;

endpackage

// ----- sv/dpt_if.sv -----
// ----------------------------------------------------------------------------
// Pair table channel interfaces
// Valid/ready channels for operation beats in and result beats out.
// ----------------------------------------------------------------------------
interface dpt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] first_char;
  logic [7:0] second_char;
  logic [7:0] digraph_char;

  modport source (output valid, mode, first_char, second_char, digraph_char,
                  input ready);
  modport sink   (input valid, mode, first_char, second_char, digraph_char,
                  output ready);
endinterface

interface dpt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_char;
  logic [2:0] status;
  logic [5:0] entry_count;
  logic       table_changed;

  modport source (output valid, result_char, status, entry_count, table_changed,
                  input ready);
  modport sink   (input valid, result_char, status, entry_count, table_changed,
                  output ready);
endinterface

// ----- sv/dpt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/dpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Pair table controller
// Sequences decode, scan, shift-down and result hand-off for each operation.
// ----------------------------------------------------------------------------
module dpt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dpt_pkg::stat_t stat_i,
  output dpt_pkg::cmd_t  cmd_o
);
  import dpt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.mode)
          MODE_LOOKUP: begin
            if (stat_i.count_zero) begin
              cmd.set_res = 1'b1;
              cmd.st_code = ST_NOTFOUND;
              state_d     = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end
          MODE_ADD: begin
            if (stat_i.full) begin
              cmd.set_res = 1'b1;
              cmd.st_code = ST_FULL;
              state_d     = S_DONE;
            end else if (stat_i.missing_add) begin
              cmd.set_res = 1'b1;
              cmd.st_code = ST_MISSING;
              state_d     = S_DONE;
            end else if (stat_i.count_zero) begin
              cmd.add_write = 1'b1;
              cmd.set_res   = 1'b1;
              cmd.st_code   = ST_DONE;
              state_d       = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end
          MODE_REMOVE: begin
            if (stat_i.count_zero) begin
              cmd.set_res = 1'b1;
              cmd.st_code = ST_EMPTY;
              state_d     = S_DONE;
            end else if (stat_i.missing_rm) begin
              cmd.set_res = 1'b1;
              cmd.st_code = ST_MISSING;
              state_d     = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end
          default: begin
            cmd.clear_tab = 1'b1;
            cmd.set_res   = 1'b1;
            cmd.st_code   = ST_DONE;
            state_d       = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.rd_sel = RD_NEXT;
        if (stat_i.hit) begin
          case (stat_i.mode)
            MODE_LOOKUP: begin
              cmd.set_res      = 1'b1;
              cmd.st_code      = ST_DONE;
              cmd.res_from_ram = 1'b1;
              state_d          = S_DONE;
            end
            MODE_ADD: begin
              cmd.set_res = 1'b1;
              cmd.st_code = ST_DEFINED;
              state_d     = S_DONE;
            end
            default: begin
              state_d = S_SHIFT;
            end
          endcase
        end else if (stat_i.last) begin
          cmd.set_res = 1'b1;
          if (stat_i.mode == MODE_ADD) begin
            cmd.add_write = 1'b1;
            cmd.st_code   = ST_DONE;
          end else begin
            cmd.st_code = ST_NOTFOUND;
          end
          state_d = S_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.rd_sel = RD_NEXT2;
        if (stat_i.last) begin
          cmd.dec_count = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.st_code   = ST_DONE;
          state_d       = S_DONE;
        end else begin
          cmd.shift_write = 1'b1;
          cmd.ptr_inc     = 1'b1;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

endmodule

// ----- sv/dpt_datapath.sv -----
// ----------------------------------------------------------------------------
// Pair table datapath
// Operation registers, scan pointer, entry count, entry RAM and result register.
// ----------------------------------------------------------------------------
module dpt_datapath #(
  parameter int unsigned TABLE_SIZE = dpt_pkg::TableSizeDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     mode_i,
  input  logic [7:0]     first_char_i,
  input  logic [7:0]     second_char_i,
  input  logic [7:0]     digraph_char_i,
  input  dpt_pkg::cmd_t  cmd_i,
  output dpt_pkg::stat_t stat_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     result_char_o,
  output logic [2:0]     status_o,
  output logic [5:0]     entry_count_o,
  output logic           table_changed_o
);
  import dpt_pkg::*;

  localparam int unsigned Depth = TABLE_SIZE - 1;
  localparam int unsigned CntW  = $clog2(TABLE_SIZE);
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  mode_e           mode_q;
  logic [7:0]      lo_q, hi_q, dig_q;
  logic [CntW-1:0] ptr_q, count_q;
  logic            changed_q;
  status_e         status_q;
  logic [7:0]      res_char_q;
  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic [2:0]      out_status_q;
  logic [5:0]      out_count_q;
  logic            out_changed_q;

  logic [CntW:0]     ptr_p1, ptr_p2, count_ext;
  logic [CntW+5:0]   count_wide;
  logic [7:0]        in_lo, in_hi;
  logic [EntryW-1:0] rdata, wdata;
  logic [AddrW-1:0]  raddr, waddr;
  logic              we;

  assign in_lo = (first_char_i < second_char_i) ? first_char_i : second_char_i;
  assign in_hi = (first_char_i < second_char_i) ? second_char_i : first_char_i;

  assign ptr_p1    = {1'b0, ptr_q} + {{CntW{1'b0}}, 1'b1};
  assign ptr_p2    = {1'b0, ptr_q} + (CntW + 1)'(2);
  assign count_ext = {1'b0, count_q};

  always_comb begin
    case (cmd_i.rd_sel)
      RD_NEXT:  raddr = ptr_p1[AddrW-1:0];
      RD_NEXT2: raddr = ptr_p2[AddrW-1:0];
      default:  raddr = '0;
    endcase
  end

  // An add appends at the count; a shift moves entry ptr+1 down to ptr.
  assign we    = cmd_i.add_write | cmd_i.shift_write;
  assign waddr = cmd_i.add_write ? count_q[AddrW-1:0] : ptr_q[AddrW-1:0];
  assign wdata = cmd_i.add_write ? {lo_q, hi_q, dig_q} : rdata;

  dpt_ram #(
    .Width (EntryW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_e'(mode_i);
      lo_q   <= in_lo;
      hi_q   <= in_hi;
      dig_q  <= digraph_char_i;
    end
    if (cmd_i.set_res) begin
      status_q   <= cmd_i.st_code;
      res_char_q <= cmd_i.res_from_ram ? rdata[7:0] : 8'd0;
    end
    if (cmd_i.load_out) begin
      out_char_q    <= res_char_q;
      out_status_q  <= status_q;
      out_count_q   <= count_wide[5:0];
      out_changed_q <= changed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      count_q     <= '0;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_p1[CntW-1:0];
      end
      if (cmd_i.clear_tab) begin
        count_q <= '0;
      end else if (cmd_i.add_write) begin
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.dec_count) begin
        count_q <= count_q - CntW'(1);
      end
      if (cmd_i.clear_tab || cmd_i.add_write || cmd_i.dec_count) begin
        changed_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign count_wide = {6'd0, count_q};

  always_comb begin
    stat_o.mode        = mode_q;
    stat_o.count_zero  = (count_q == '0);
    stat_o.full        = (count_q == CntW'(Depth));
    stat_o.missing_add = (lo_q == 8'd0) || (dig_q == 8'd0);
    stat_o.missing_rm  = (lo_q == 8'd0);
    stat_o.hit         = (rdata[23:16] == lo_q) && (rdata[15:8] == hi_q);
    stat_o.last        = (ptr_p1 == count_ext);
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign result_char_o   = out_char_q;
  assign status_o        = out_status_q;
  assign entry_count_o   = out_count_q;
  assign table_changed_o = out_changed_q;

endmodule

// ----- sv/digraph_pair_table.sv -----
// ----------------------------------------------------------------------------
// Digraph pair table
// Compacted table of unordered character pairs mapped to digraph characters,
// with lookup, add, remove and clear operations.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Beat contents
//   --------+-----------+---------------------------------------------------
//   in_i    | sink      | mode, first_char, second_char, digraph_char
//   out_o   | source    | result_char, status, entry_count, table_changed
//
// Each beat is one operation and gives exactly one result beat. A lookup,
// add or remove scans the held entries in order until it hits one or
// reaches the end; a remove that hits then shifts the later entries down
// by one place. The scan reads one entry RAM word per cycle. A clear, or
// any operation settled without a scan, passes from the decode state
// straight to the done state, and in the cycle in which a result is
// offered the next beat can already be taken.
// After reset the table is empty; the entry RAM needs no clearing pass.
// The next beat is accepted while a result still waits in the output
// register; the block only stalls once that next result is ready as well.
//
module digraph_pair_table #(
  parameter int unsigned TABLE_SIZE = dpt_pkg::TableSizeDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  dpt_in_if.sink    in_i,
  dpt_out_if.source out_o
);
  import dpt_pkg::*;

  `include "assert_macros.svh"

  cmd_t  cmd;
  stat_t stat;

  // The controller owns ready: a beat is taken only when the sequencer is
  // idle, and the datapath captures the beat on the same edge.
  dpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dpt_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (in_i.mode),
    .first_char_i    (in_i.first_char),
    .second_char_i   (in_i.second_char),
    .digraph_char_i  (in_i.digraph_char),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .result_char_o   (out_o.result_char),
    .status_o        (out_o.status),
    .entry_count_o   (out_o.entry_count),
    .table_changed_o (out_o.table_changed)
  );

  // Once a beat is taken, the block is not ready again in the next cycle.
  `DPT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready, "input accepted while still busy")

  // An entry is only appended to a table with room and a complete argument.
  `DPT_ASSERT_IMPL(a_add_allowed, clk_i, rst_ni, cmd.add_write, !stat.full && !stat.missing_add, "entry appended to a full table or with a missing character")

  // The shift-down never copies from beyond the last held entry.
  `DPT_ASSERT_IMPL(a_shift_in_range, clk_i, rst_ni, cmd.shift_write, !stat.last, "shift copied past the last entry")

  // A result is never written over one that has not been taken.
  `DPT_ASSERT_IMPL(a_no_result_overwrite, clk_i, rst_ni, cmd.load_out, !out_o.valid || out_o.ready, "result register overwritten")

endmodule
